// ===== sv/cpv_pkg.sv =====
// cpv_pkg: shared widths, register indexes and reset values for the coin pulse validator
// no dependencies; imported by the interfaces and the top level
`default_nettype none

package cpv_pkg;

    // field and register widths
    localparam int unsigned TICK_W   = 8;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned CREDIT_W = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_TICKS   = 2'd0,
        CFG_STUCK_LIMIT = 2'd1,
        CFG_COIN_VALUE  = 2'd2
    } t_cfg_idx;

    // item operation codes
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_READ = 1'b1
    } t_op;

    // register reset values
    localparam logic [TICK_W-1:0]   MIN_TICKS_RST   = 8'd3;
    localparam logic [TICK_W-1:0]   STUCK_LIMIT_RST = 8'd250;
    localparam logic [CREDIT_W-1:0] COIN_VALUE_RST  = 16'd1;

    // idle-phase counter ceiling
    localparam logic [TICK_W-1:0]   TICK_MAX = {TICK_W{1'b1}};

endpackage

`default_nettype wire

// ===== sv/cpv_in_if.sv =====
// cpv_in_if: valid/ready channel carrying one input item (tick or credit read)
// depends on cpv_pkg
`default_nettype none

interface cpv_in_if;
    import cpv_pkg::*;

    logic valid;
    logic ready;
    logic op;
    logic line_low;

    modport source (output valid, output op, output line_low, input ready);
    modport sink   (input valid, input op, input line_low, output ready);
endinterface

`default_nettype wire

// ===== sv/cpv_out_if.sv =====
// cpv_out_if: valid/ready channel carrying one result item
// depends on cpv_pkg for the credit width
`default_nettype none

interface cpv_out_if;
    import cpv_pkg::*;

    logic                valid;
    logic                ready;
    logic [CREDIT_W-1:0] credit;
    logic                stuck_fault;
    logic                coin_seen;

    modport source (output valid, output credit, output stuck_fault, output coin_seen,
                    input ready);
    modport sink   (input valid, input credit, input stuck_fault, input coin_seen,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/coin_pulse_validator.sv =====
// coin_pulse_validator: pulse-width coin qualifier, stuck-line detector and credit counter
// depends on cpv_pkg, cpv_in_if and cpv_out_if
//
//  channel  | direction | payload                          | handshake
//  ---------+-----------+----------------------------------+-------------
//  i_item   | in        | op, line_low                     | valid/ready
//  o_result | out       | credit, stuck_fault, coin_seen   | valid/ready
//  i_cfg_*  | in        | idx (2 bit), data (16 bit)       | write enable
//
// one item per clock sustained while o_result is not stalled; an accepted item goes through
// the input register, then the state update and result register together in a single pass
// an item leaves the input register only when the result register is empty or being taken;
// a waiting result stops input once the input register also holds an item
// synchronous active-low reset clears the pulse state, coin count and both valid bits;
// registers return to min_ticks 3, stuck_limit 250, coin_value 1
`default_nettype none

module coin_pulse_validator
    import cpv_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    cpv_in_if.sink              i_item,
    cpv_out_if.source           o_result,
    input  wire                 i_cfg_we,
    input  wire [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [CFG_W-1:0]     i_cfg_data
);

    // configuration registers
    logic [TICK_W-1:0]   r_min_ticks;
    logic [TICK_W-1:0]   r_stuck_limit;
    logic [CREDIT_W-1:0] r_coin_value;

    // input stage
    logic r_in_valid;
    logic r_in_op;
    logic r_in_line_low;

    // pulse state
    logic [TICK_W-1:0]  r_time_count,  n_time_count;
    logic               r_in_low,      n_in_low;
    logic               r_qualified,   n_qualified;
    logic [COUNT_W-1:0] r_coin_count,  n_coin_count;
    logic               r_fault,       n_fault;
    logic               n_coin_seen;
    logic [CREDIT_W-1:0] n_credit;

    // result stage
    logic                r_out_valid;
    logic [CREDIT_W-1:0] r_out_credit;
    logic                r_out_fault;
    logic                r_out_seen;

    logic out_free;
    logic advance;
    logic [COUNT_W+CREDIT_W-1:0] product;

    assign out_free     = !r_out_valid || o_result.ready;
    assign advance      = r_in_valid && out_free;
    assign i_item.ready = !r_in_valid || out_free;

    // configuration writes; unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ticks   <= MIN_TICKS_RST;
            r_stuck_limit <= STUCK_LIMIT_RST;
            r_coin_value  <= COIN_VALUE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_TICKS:   r_min_ticks   <= i_cfg_data[TICK_W-1:0];
                CFG_STUCK_LIMIT: r_stuck_limit <= i_cfg_data[TICK_W-1:0];
                CFG_COIN_VALUE:  r_coin_value  <= i_cfg_data[CREDIT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_op       <= i_item.op;
            r_in_line_low <= i_item.line_low;
        end
    end

    // credit product, truncated to the credit width
    assign product = {{CREDIT_W{1'b0}}, r_coin_count} * {{COUNT_W{1'b0}}, r_coin_value};

    // next pulse state and result for the item in the input register
    always_comb begin
        n_time_count = r_time_count;
        n_in_low     = r_in_low;
        n_qualified  = r_qualified;
        n_coin_count = r_coin_count;
        n_fault      = r_fault;
        n_coin_seen  = 1'b0;
        n_credit     = '0;
        unique case (t_op'(r_in_op))
            OP_READ: begin
                n_credit     = product[CREDIT_W-1:0];
                n_coin_count = '0;
            end
            OP_TICK: begin
                if (r_in_line_low) begin
                    if (r_in_low) begin
                        // low phase: count up to the stuck limit
                        if (r_time_count < r_stuck_limit) begin
                            n_time_count = r_time_count + 1'b1;
                        end
                        if (n_time_count >= r_min_ticks) begin
                            n_qualified = 1'b1;
                        end
                    end else begin
                        n_in_low     = 1'b1;
                        n_qualified  = 1'b0;
                        n_time_count = '0;
                    end
                end else begin
                    if (r_in_low) begin
                        n_time_count = '0;
                        n_in_low     = 1'b0;
                    end else begin
                        // idle high phase: saturating count, coin once long enough after a qualified pulse
                        if (r_time_count != TICK_MAX) begin
                            n_time_count = r_time_count + 1'b1;
                        end
                        if (n_time_count >= r_min_ticks && r_qualified) begin
                            n_coin_count = r_coin_count + 1'b1;
                            n_qualified  = 1'b0;
                            n_time_count = '0;
                            n_coin_seen  = 1'b1;
                        end
                    end
                end
                n_fault = (n_time_count >= r_stuck_limit);
            end
            default: ;
        endcase
    end

    // pulse state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_count <= '0;
            r_in_low     <= 1'b0;
            r_qualified  <= 1'b0;
            r_coin_count <= '0;
            r_fault      <= 1'b0;
        end else if (advance) begin
            r_time_count <= n_time_count;
            r_in_low     <= n_in_low;
            r_qualified  <= n_qualified;
            r_coin_count <= n_coin_count;
            r_fault      <= n_fault;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_credit <= n_credit;
            r_out_fault  <= n_fault;
            r_out_seen   <= n_coin_seen;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.credit      = r_out_credit;
    assign o_result.stuck_fault = r_out_fault;
    assign o_result.coin_seen   = r_out_seen;

endmodule

`default_nettype wire

// ===== tb/sv/cpv_tb_pkg.sv =====
`timescale 1ns / 1ps
// cpv_tb_pkg: coin credit predictor and result checker for the coin pulse validator bench
// depends on cpv_pkg for widths, register indexes, operation codes and reset values

package cpv_tb_pkg;
    import cpv_pkg::*;

    // one result item as the block should present it
    typedef struct packed {
        logic [CREDIT_W-1:0] credit;
        logic                stuck_fault;
        logic                coin_seen;
    } t_credit_result;

    class coin_credit_board;
        // register copies
        logic [TICK_W-1:0]   min_ticks;
        logic [TICK_W-1:0]   stuck_limit;
        logic [CREDIT_W-1:0] coin_value;

        // pulse state copies
        logic [TICK_W-1:0]   time_count;
        logic [COUNT_W-1:0]  coin_count;
        bit                  in_low;
        bit                  qualified;
        bit                  fault;

        t_credit_result      pending_results[$];

        int unsigned         errors;
        int unsigned         checked;
        int unsigned         coins;
        int unsigned         reads;
        int unsigned         faulty;

        function new();
            min_ticks   = MIN_TICKS_RST;
            stuck_limit = STUCK_LIMIT_RST;
            coin_value  = COIN_VALUE_RST;
            time_count  = '0;
            coin_count  = '0;
            in_low      = 1'b0;
            qualified   = 1'b0;
            fault       = 1'b0;
        endfunction

        // register write; an index past the last register changes nothing
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_MIN_TICKS:   min_ticks   = data[TICK_W-1:0];
                CFG_STUCK_LIMIT: stuck_limit = data[TICK_W-1:0];
                CFG_COIN_VALUE:  coin_value  = data[CREDIT_W-1:0];
                default: ;
            endcase
        endfunction

        // advance the pulse state for one accepted item and queue its result
        function void accept_item(t_op op, logic line_low);
            t_credit_result res;
            res = '0;
            if (op == OP_READ) begin
                res.credit = coin_value * {{(CREDIT_W-COUNT_W){1'b0}}, coin_count};
                coin_count = '0;
                reads++;
            end else begin
                if (line_low) begin
                    if (in_low) begin
                        if (time_count < stuck_limit)
                            time_count = time_count + 1'b1;
                        if (time_count >= min_ticks)
                            qualified = 1'b1;
                    end else begin
                        in_low     = 1'b1;
                        qualified  = 1'b0;
                        time_count = '0;
                    end
                end else begin
                    if (in_low) begin
                        time_count = '0;
                        in_low     = 1'b0;
                    end else begin
                        // idle count sticks at the ceiling
                        if (time_count != TICK_MAX)
                            time_count = time_count + 1'b1;
                        if (time_count >= min_ticks && qualified) begin
                            coin_count    = coin_count + 1'b1;
                            qualified     = 1'b0;
                            time_count    = '0;
                            res.coin_seen = 1'b1;
                            coins++;
                        end
                    end
                end
                fault = (time_count >= stuck_limit);
            end
            res.stuck_fault = fault;
            if (fault)
                faulty++;
            pending_results.push_back(res);
        endfunction

        // compare one accepted result with the oldest expectation
        function void take_result(logic [CREDIT_W-1:0] credit, logic stuck_fault,
                                  logic coin_seen);
            t_credit_result want;
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: credit %0d fault %0b seen %0b",
                       credit, stuck_fault, coin_seen);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (credit !== want.credit) begin
                $error("credit mismatch: expected %0d, actual %0d", want.credit, credit);
                errors++;
            end
            if (stuck_fault !== want.stuck_fault) begin
                $error("stuck_fault mismatch: expected %0b, actual %0b",
                       want.stuck_fault, stuck_fault);
                errors++;
            end
            if (coin_seen !== want.coin_seen) begin
                $error("coin_seen mismatch: expected %0b, actual %0b",
                       want.coin_seen, coin_seen);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_coin_pulse_validator.sv =====
`timescale 1ns / 1ps
// tb_coin_pulse_validator: random pulse trains and credit reads against a coin credit predictor
// depends on cpv_pkg, cpv_in_if, cpv_out_if, cpv_tb_pkg and coin_pulse_validator

module tb_coin_pulse_validator;
    import cpv_pkg::*;
    import cpv_tb_pkg::*;

    // index past the last register, for the ignored-write case
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int unsigned DRAIN_CYCLES = 4;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    bit                   gaps_on;
    int unsigned          items_sent;
    int unsigned          cur_min;
    int unsigned          cur_stuck;

    coin_credit_board     board;

    cpv_in_if  item_if ();
    cpv_out_if result_if ();

    coin_pulse_validator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_result   (result_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // result side: stall in bursts while gaps are enabled
    initial begin
        result_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (gaps_on && $urandom_range(0, 9) == 0) begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            result_if.ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready)
            board.take_result(result_if.credit, result_if.stuck_fault, result_if.coin_seen);
    end

    // offer one item and hold it until taken; valid stays high on return
    task automatic send_item(t_op op, logic line_low);
        if (gaps_on && $urandom_range(0, 11) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        item_if.valid    <= 1'b1;
        item_if.op       <= op;
        item_if.line_low <= line_low;
        do @(posedge i_clk); while (!item_if.ready);
        board.accept_item(op, line_low);
        items_sent++;
    endtask

    // stop offering items until every expected result is back
    task automatic hold_until_drained();
        item_if.valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // load all three registers; 8-bit registers get junk in the unused upper bits
    task automatic set_config(int unsigned min_t, int unsigned stuck, int unsigned value);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [CFG_W-1:0]     data [3];
        idx[0]  = CFG_MIN_TICKS;
        idx[1]  = CFG_STUCK_LIMIT;
        idx[2]  = CFG_COIN_VALUE;
        data[0] = {8'($urandom), 8'(min_t)};
        data[1] = {8'($urandom), 8'(stuck)};
        data[2] = 16'(value);
        for (int k = 0; k < 3; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idx[k];
            cfg_data <= data[k];
            @(posedge i_clk);
            board.write_reg(idx[k], data[k]);
        end
        cfg_we    <= 1'b0;
        cur_min   = min_t;
        cur_stuck = stuck;
    endtask

    // mostly near the qualifying length, sometimes short, sometimes past the stuck limit
    function automatic int unsigned pulse_len();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return cur_min + $urandom_range(0, 2);
        else if (r < 17)
            return $urandom_range(1, cur_min);
        return $urandom_range(cur_min, cur_stuck + 4);
    endfunction

    task automatic send_run(logic line_low, int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            send_item(OP_TICK, line_low);
    endtask

    // well-formed pulses with random widths, plus reads, noise and long idle stretches
    task automatic run_random(int unsigned n);
        int unsigned start;
        int unsigned r;
        start = items_sent;
        while (items_sent - start < n) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                send_item(OP_READ, 1'($urandom));
            else if (r < 10)
                send_item(OP_TICK, 1'($urandom));
            else if (r == 10)
                send_run(1'b0, $urandom_range(250, 300));
            else if (r == 11)
                hold_until_drained();
            else begin
                send_run(1'b1, pulse_len());
                send_run(1'b0, pulse_len());
            end
        end
    endtask

    initial begin
        board             = new();
        gaps_on           = 1'b1;
        items_sent        = 0;
        cur_min           = MIN_TICKS_RST;
        cur_stuck         = STUCK_LIMIT_RST;
        i_rst_n          <= 1'b0;
        item_if.valid    <= 1'b0;
        item_if.op       <= OP_TICK;
        item_if.line_low <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= CFG_MIN_TICKS;
        cfg_data         <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // write to a missing register must leave the reset values alone
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_IDX_SPARE;
        cfg_data <= 16'hFFFF;
        @(posedge i_clk);
        board.write_reg(CFG_IDX_SPARE, 16'hFFFF);
        cfg_we   <= 1'b0;

        // reset settings: read ignores the line, one clean coin, read then read again
        send_item(OP_READ, 1'b1);
        send_item(OP_TICK, 1'b0);
        send_run(1'b1, 4);
        send_run(1'b0, 4);
        send_item(OP_READ, 1'b0);
        send_item(OP_READ, 1'b1);
        hold_until_drained();

        // stuck limit of zero: fault always set, no coin can qualify
        set_config(1, 0, 16'hFFFF);
        send_run(1'b1, 3);
        send_run(1'b0, 3);
        send_item(OP_READ, 1'b0);
        hold_until_drained();

        // random phases over several settings, extremes included
        set_config(2, 12, 5);
        run_random(60);
        hold_until_drained();
        run_random(60);
        hold_until_drained();

        set_config(1, 255, 16'hFFFF);
        run_random(60);
        hold_until_drained();

        // minimum above stuck limit: no coin ever qualifies
        set_config(255, 1, 0);
        send_run(1'b1, 6);
        send_run(1'b0, 6);
        send_item(OP_READ, 1'b0);
        hold_until_drained();

        set_config(6, 0, 7);
        run_random(60);
        hold_until_drained();

        set_config($urandom_range(2, 8), $urandom_range(20, 60), $urandom_range(0, 65535));
        run_random(80);
        hold_until_drained();

        // more than 256 coins without a read so the count wraps
        set_config(1, 255, 3);
        send_item(OP_READ, 1'b0);
        for (int k = 0; k < 260; k++) begin
            send_run(1'b1, 2);
            send_run(1'b0, 2);
        end
        send_item(OP_READ, 1'b0);
        hold_until_drained();

        // closing stretch at full rate on both sides
        gaps_on = 1'b0;
        set_config(MIN_TICKS_RST, STUCK_LIMIT_RST, COIN_VALUE_RST);
        run_random(50);
        hold_until_drained();
        set_config(3, 8, 11);
        run_random(50);

        hold_until_drained();
        repeat (10) @(posedge i_clk);

        $display("ran %0d items, %0d results checked: %0d coins, %0d reads, %0d with stuck fault",
                 items_sent, board.checked, board.coins, board.reads, board.faulty);
        $display("settings covered min_ticks 1..255, stuck_limit 0..255, coin_value 0..65535");
        if (board.errors == 0 && board.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hang guard
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/cpv_pkg.sv
sv/cpv_in_if.sv
sv/cpv_out_if.sv
sv/coin_pulse_validator.sv
tb/sv/cpv_tb_pkg.sv
tb/sv/tb_coin_pulse_validator.sv
